FILE: src/bfm_pkg.sv
package bfm_pkg;

  localparam int unsigned DEF_MAX_BITS      = 1048576;
  localparam int unsigned DEF_MAX_KEY_BYTES = 1024;
  localparam int unsigned MAX_HASHES        = 4;
  localparam int unsigned SEED_LANES        = 4;
  localparam int unsigned LANE_LIMIT        = (MAX_HASHES < SEED_LANES) ? MAX_HASHES : SEED_LANES;
  localparam int unsigned LANE_W            = 2;

  localparam int unsigned FB_W   = 21;
  localparam int unsigned HC_W   = 3;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 32;
  localparam int unsigned CB_W   = 4;
  localparam int unsigned NEW_W  = 3;
  localparam int unsigned OCC_W  = 21;

  localparam logic [CIDX_W-1:0] CFG_FILTER_BITS = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HASH_COUNT  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SEED_ZERO   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SEED_ONE    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SEED_TWO    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_SEED_THREE  = 3'd5;

  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] BLK_AD1 = 64'h0000000052dce729;
  localparam logic [63:0] BLK_AD2 = 64'h0000000038495ab5;

  typedef enum logic [1:0] {
    CS_C1,
    CS_C2,
    CS_F1,
    CS_F2
  } csel_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CLR,
    OP_W_LO,
    OP_W_HI,
    OP_ROT31,
    OP_ROT33,
    OP_MUL,
    OP_K1,
    OP_K2,
    OP_BLK1,
    OP_BLK2,
    OP_FA,
    OP_FB,
    OP_XS_F1,
    OP_XS_F2,
    OP_XS_W,
    OP_F1_W,
    OP_F2_W,
    OP_SUM,
    OP_DIV,
    OP_IDX,
    OP_RD,
    OP_CHK,
    OP_OUT,
    OP_ERR
  } op_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DISP,
    S_K1L, S_K1M1, S_K1R, S_K1M2, S_K1S,
    S_K2L, S_K2M1, S_K2R, S_K2M2, S_K2S,
    S_BLK1, S_BLK2,
    S_FA, S_FB,
    S_A1X, S_A1M, S_A1S, S_A1N, S_A1E,
    S_A2X, S_A2M, S_A2S, S_A2N, S_A2E,
    S_SUM, S_DIV, S_IDX,
    S_RD, S_CHK,
    S_OUT, S_ERR
  } state_t;

  typedef struct packed {
    op_t               op;
    csel_t             csel;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic              last;
    logic              ovf;
    logic              blk;
    logic [LANE_W-1:0] lane_max;
    logic              mul_done;
    logic              div_done;
    logic              clr_done;
  } sts_t;

  function automatic logic [63:0] xs33(input logic [63:0] x);
    return x ^ (x >> 33);
  endfunction

endpackage

FILE: src/bfm_ctrl.sv
module bfm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bfm_pkg::sts_t sts,
  output bfm_pkg::cmd_t cmd,
  output logic          busy
);
  import bfm_pkg::*;

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              last_lane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  assign last_lane = (lane_r == sts.lane_max);
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    cmd.op    = OP_NOP;
    cmd.csel  = CS_C1;
    cmd.lane  = lane_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        lane_nxt = '0;
        if (start) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts.last && sts.ovf) state_nxt = S_ERR;
        else if (sts.last || sts.blk) state_nxt = S_K1L;
        else state_nxt = S_IDLE;
      end
      S_K1L: begin
        cmd.op    = OP_W_LO;
        state_nxt = S_K1M1;
      end
      S_K1M1: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_C1;
        if (sts.mul_done) state_nxt = S_K1R;
      end
      S_K1R: begin
        cmd.op    = OP_ROT31;
        state_nxt = S_K1M2;
      end
      S_K1M2: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_C2;
        if (sts.mul_done) state_nxt = S_K1S;
      end
      S_K1S: begin
        cmd.op    = OP_K1;
        state_nxt = S_K2L;
      end
      S_K2L: begin
        cmd.op    = OP_W_HI;
        state_nxt = S_K2M1;
      end
      S_K2M1: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_C2;
        if (sts.mul_done) state_nxt = S_K2R;
      end
      S_K2R: begin
        cmd.op    = OP_ROT33;
        state_nxt = S_K2M2;
      end
      S_K2M2: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_C1;
        if (sts.mul_done) state_nxt = S_K2S;
      end
      S_K2S: begin
        cmd.op    = OP_K2;
        state_nxt = sts.blk ? S_BLK1 : S_FA;
      end
      S_BLK1: begin
        cmd.op    = OP_BLK1;
        state_nxt = S_BLK2;
      end
      S_BLK2: begin
        cmd.op    = OP_BLK2;
        state_nxt = sts.last ? S_FA : S_IDLE;
      end
      S_FA: begin
        cmd.op    = OP_FA;
        state_nxt = S_FB;
      end
      S_FB: begin
        cmd.op    = OP_FB;
        state_nxt = S_A1X;
      end
      S_A1X: begin
        cmd.op    = OP_XS_F1;
        state_nxt = S_A1M;
      end
      S_A1M: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_F1;
        if (sts.mul_done) state_nxt = S_A1S;
      end
      S_A1S: begin
        cmd.op    = OP_XS_W;
        state_nxt = S_A1N;
      end
      S_A1N: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_F2;
        if (sts.mul_done) state_nxt = S_A1E;
      end
      S_A1E: begin
        cmd.op    = OP_F1_W;
        state_nxt = S_A2X;
      end
      S_A2X: begin
        cmd.op    = OP_XS_F2;
        state_nxt = S_A2M;
      end
      S_A2M: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_F1;
        if (sts.mul_done) state_nxt = S_A2S;
      end
      S_A2S: begin
        cmd.op    = OP_XS_W;
        state_nxt = S_A2N;
      end
      S_A2N: begin
        cmd.op   = OP_MUL;
        cmd.csel = CS_F2;
        if (sts.mul_done) state_nxt = S_A2E;
      end
      S_A2E: begin
        cmd.op    = OP_F2_W;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.op = OP_IDX;
        if (last_lane) begin
          lane_nxt  = '0;
          state_nxt = S_RD;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_FA;
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op = OP_CHK;
        if (last_lane) begin
          lane_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        cmd.op    = OP_OUT;
        state_nxt = S_IDLE;
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/bfm_dp.sv
module bfm_dp #(
  parameter int unsigned MAX_BITS      = bfm_pkg::DEF_MAX_BITS,
  parameter int unsigned MAX_KEY_BYTES = bfm_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bfm_pkg::cmd_t                cmd,
  output bfm_pkg::sts_t                sts,
  input  logic                         in_mode,
  input  logic [63:0]                  in_key_chunk,
  input  logic [bfm_pkg::CB_W-1:0]     in_chunk_bytes,
  input  logic                         in_last_chunk,
  input  logic                         cfg_we,
  input  logic [bfm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bfm_pkg::CDAT_W-1:0]   cfg_data,
  output logic                         out_valid,
  output logic                         out_present,
  output logic [bfm_pkg::NEW_W-1:0]    out_bits_newly_set,
  output logic [bfm_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_length_error
);
  import bfm_pkg::*;

  localparam int unsigned ROWS = (MAX_BITS + 63) / 64;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IXW  = RW + 6;
  localparam int unsigned WB   = $clog2(MAX_BITS + 1);
  localparam int unsigned LW   = $clog2(MAX_KEY_BYTES + 1);

  logic [FB_W-1:0]   filter_bits_r;
  logic [HC_W-1:0]   hash_count_r;
  logic [SEED_W-1:0] seed_r [SEED_LANES];

  logic [63:0]       h1_r [SEED_LANES];
  logic [63:0]       h2_r [SEED_LANES];
  logic [63:0]       held_r, chunk_r, w_r, acc_r, k1_r, k2_r, f1_r, f2_r, dvd_r;
  logic              held_v_r, ovf_r, last_r, blk_r, mode_r, use_lo_r, use_hi_r;
  logic [LW-1:0]     key_len_r;
  logic [1:0]        mstep_r;
  logic [5:0]        dcnt_r;
  logic [WB-1:0]     rem_r;
  logic [IXW-1:0]    idx_r [SEED_LANES];
  logic [RW-1:0]     clr_cnt_r;
  logic [63:0]       mem_r [ROWS];
  logic [63:0]       rd_r;
  logic              present_r;
  logic [NEW_W-1:0]  newly_r;
  logic [OCC_W-1:0]  total_r;

  logic              out_valid_r, out_present_r, out_err_r;
  logic [NEW_W-1:0]  out_newly_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [CB_W-1:0]   nb;
  logic [63:0]       masked;
  logic              fresh, new_ovf;
  logic [LW:0]       len_sum;
  logic [WB-1:0]     width_w;
  logic [LANE_W-1:0] lane_max;
  logic [63:0]       cval;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [WB:0]       r2;
  logic              r2_ge;
  logic [IXW-1:0]    cur_idx;
  logic [RW-1:0]     cur_row;
  logic              cur_bit;
  logic [63:0]       bit_mask;

  always_comb begin
    nb = (in_chunk_bytes > CB_W'(8) || !in_last_chunk) ? CB_W'(8) : in_chunk_bytes;
    for (int j = 0; j < 8; j++) begin
      masked[8*j +: 8] = (CB_W'(j) < nb) ? in_key_chunk[8*j +: 8] : 8'h00;
    end
  end

  assign fresh   = (key_len_r == '0) && !held_v_r && !ovf_r;
  assign len_sum = {1'b0, key_len_r} + (LW + 1)'(nb);
  assign new_ovf = ovf_r || (len_sum > (LW + 1)'(MAX_KEY_BYTES));

  always_comb begin
    priority if (filter_bits_r == '0) width_w = WB'(1);
    else if (32'(filter_bits_r) > 32'(MAX_BITS)) width_w = WB'(MAX_BITS);
    else width_w = WB'(filter_bits_r);
    priority if (hash_count_r == '0) lane_max = '0;
    else if (32'(hash_count_r) > 32'(LANE_LIMIT)) lane_max = LANE_W'(LANE_LIMIT - 1);
    else lane_max = LANE_W'(hash_count_r - 1'b1);
  end

  always_comb begin
    unique case (cmd.csel)
      CS_C1:   cval = MM_C1;
      CS_C2:   cval = MM_C2;
      CS_F1:   cval = MM_F1;
      CS_F2:   cval = MM_F2;
      default: cval = MM_C1;
    endcase
  end

  assign mul_a = (mstep_r == 2'd2) ? w_r[63:32] : w_r[31:0];
  assign mul_b = (mstep_r == 2'd1) ? cval[63:32] : cval[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  assign r2    = {rem_r, dvd_r[63]};
  assign r2_ge = (r2 >= {1'b0, width_w});

  assign cur_idx  = idx_r[cmd.lane];
  assign cur_row  = cur_idx[IXW-1:6];
  assign cur_bit  = rd_r[cur_idx[5:0]];
  assign bit_mask = 64'd1 << cur_idx[5:0];

  assign sts.last     = last_r;
  assign sts.ovf      = ovf_r;
  assign sts.blk      = blk_r;
  assign sts.lane_max = lane_max;
  assign sts.mul_done = (cmd.op == OP_MUL) && (mstep_r == 2'd2);
  assign sts.div_done = (cmd.op == OP_DIV) && (dcnt_r == 6'd63);
  assign sts.clr_done = (cmd.op == OP_CLR) && (clr_cnt_r == RW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bits_r <= FB_W'(DEF_MAX_BITS);
      hash_count_r  <= HC_W'(4);
      for (int i = 0; i < SEED_LANES; i++) seed_r[i] <= SEED_W'(i + 1);
      held_v_r      <= 1'b0;
      ovf_r         <= 1'b0;
      key_len_r     <= '0;
      mstep_r       <= '0;
      dcnt_r        <= '0;
      clr_cnt_r     <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILTER_BITS: filter_bits_r <= cfg_data[FB_W-1:0];
          CFG_HASH_COUNT:  hash_count_r  <= cfg_data[HC_W-1:0];
          CFG_SEED_ZERO:   seed_r[0]     <= cfg_data;
          CFG_SEED_ONE:    seed_r[1]     <= cfg_data;
          CFG_SEED_TWO:    seed_r[2]     <= cfg_data;
          CFG_SEED_THREE:  seed_r[3]     <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_CLR: clr_cnt_r <= clr_cnt_r + 1'b1;
        OP_ACCEPT: begin
          ovf_r <= new_ovf;
          if (!new_ovf) key_len_r <= len_sum[LW-1:0];
          if (!in_last_chunk) begin
            if (!new_ovf) held_v_r <= !held_v_r;
          end
        end
        OP_MUL: mstep_r <= (mstep_r == 2'd2) ? 2'd0 : mstep_r + 1'b1;
        OP_DIV: dcnt_r <= dcnt_r + 1'b1;
        OP_CHK: begin
          if (!mode_r && !cur_bit) total_r <= total_r + 1'b1;
        end
        OP_OUT, OP_ERR: begin
          out_valid_r <= 1'b1;
          held_v_r    <= 1'b0;
          ovf_r       <= 1'b0;
          key_len_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        if (fresh) begin
          for (int i = 0; i < SEED_LANES; i++) begin
            h1_r[i] <= 64'(seed_r[i]);
            h2_r[i] <= 64'(seed_r[i]);
          end
        end
        last_r    <= in_last_chunk;
        mode_r    <= in_mode;
        present_r <= 1'b1;
        newly_r   <= '0;
        if (!in_last_chunk) begin
          blk_r    <= held_v_r && !new_ovf;
          use_lo_r <= 1'b1;
          use_hi_r <= 1'b1;
          chunk_r  <= in_key_chunk;
          if (!held_v_r) held_r <= in_key_chunk;
        end else begin
          blk_r    <= held_v_r && (nb == CB_W'(8));
          use_lo_r <= held_v_r || (nb != '0);
          use_hi_r <= held_v_r && (nb != '0);
          chunk_r  <= masked;
          if (!held_v_r) held_r <= masked;
        end
      end
      OP_W_LO:  w_r <= held_r;
      OP_W_HI:  w_r <= chunk_r;
      OP_ROT31: w_r <= {w_r[32:0], w_r[63:33]};
      OP_ROT33: w_r <= {w_r[30:0], w_r[63:31]};
      OP_MUL: begin
        unique case (mstep_r)
          2'd0:    acc_r <= prod;
          2'd1:    acc_r <= acc_r + {prod[31:0], 32'd0};
          default: w_r   <= acc_r + {prod[31:0], 32'd0};
        endcase
      end
      OP_K1: k1_r <= use_lo_r ? w_r : 64'd0;
      OP_K2: k2_r <= use_hi_r ? w_r : 64'd0;
      OP_BLK1: begin
        for (int i = 0; i < SEED_LANES; i++) begin
          logic [63:0] t;
          logic [63:0] x;
          x = h1_r[i] ^ k1_r;
          t = {x[36:0], x[63:37]} + h2_r[i];
          h1_r[i] <= (t << 2) + t + BLK_AD1;
        end
      end
      OP_BLK2: begin
        for (int i = 0; i < SEED_LANES; i++) begin
          logic [63:0] t;
          logic [63:0] x;
          x = h2_r[i] ^ k2_r;
          t = {x[32:0], x[63:33]} + h1_r[i];
          h2_r[i] <= (t << 2) + t + BLK_AD2;
        end
        k1_r <= 64'd0;
        k2_r <= 64'd0;
      end
      OP_FA: begin
        f1_r <= (h1_r[cmd.lane] ^ k1_r ^ 64'(key_len_r))
              + (h2_r[cmd.lane] ^ k2_r ^ 64'(key_len_r));
        f2_r <= h2_r[cmd.lane] ^ k2_r ^ 64'(key_len_r);
      end
      OP_FB:    f2_r <= f2_r + f1_r;
      OP_XS_F1: w_r <= xs33(f1_r);
      OP_XS_F2: w_r <= xs33(f2_r);
      OP_XS_W:  w_r <= xs33(w_r);
      OP_F1_W:  f1_r <= xs33(w_r);
      OP_F2_W:  f2_r <= xs33(w_r);
      OP_SUM: begin
        dvd_r <= f1_r + f2_r;
        rem_r <= '0;
      end
      OP_DIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= r2_ge ? WB'(r2 - {1'b0, width_w}) : WB'(r2);
      end
      OP_IDX: idx_r[cmd.lane] <= IXW'(rem_r);
      OP_RD:  rd_r <= mem_r[cur_row];
      OP_CHK: begin
        if (!cur_bit) begin
          present_r <= 1'b0;
          if (!mode_r) newly_r <= newly_r + 1'b1;
        end
      end
      OP_OUT: begin
        out_present_r <= present_r;
        out_newly_r   <= newly_r;
        out_occ_r     <= total_r;
        out_err_r     <= 1'b0;
      end
      OP_ERR: begin
        out_present_r <= 1'b0;
        out_newly_r   <= '0;
        out_occ_r     <= total_r;
        out_err_r     <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) begin
      mem_r[clr_cnt_r] <= 64'd0;
    end else if (cmd.op == OP_CHK && !mode_r && !cur_bit) begin
      mem_r[cur_row] <= rd_r | bit_mask;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_present        = out_present_r;
  assign out_bits_newly_set = out_newly_r;
  assign out_occupancy      = out_occ_r;
  assign out_length_error   = out_err_r;

endmodule

FILE: src/bloom_filter_murmur_add_test.sv
// channel  | handshake        | payload
// ---------+------------------+-----------------------------------------------
// input    | start, busy      | in_mode, in_key_chunk, in_chunk_bytes,
//          |                  | in_last_chunk
// result   | out_valid        | out_present, out_bits_newly_set, out_occupancy,
//          |                  | out_length_error
// config   | cfg_we           | cfg_index, cfg_data
//
// Take an item when start is high and busy is low; out_valid is a one-cycle
// strobe that the receiver cannot stall. A middle chunk that completes a 16-byte
// block runs four multiplies on one 32x32 multiplier.
// A last chunk also runs those multiplies and, if it completes a block, the block
// mix; each active hash then adds four multiplies, a 64-step remainder and a bit
// store read and update. After reset busy stays high while the store is cleared.
module bloom_filter_murmur_add_test #(
  parameter int unsigned MAX_BITS      = bfm_pkg::DEF_MAX_BITS,
  parameter int unsigned MAX_KEY_BYTES = bfm_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [63:0]                  in_key_chunk,
  input  logic [bfm_pkg::CB_W-1:0]     in_chunk_bytes,
  input  logic                         in_last_chunk,
  output logic                         out_valid,
  output logic                         out_present,
  output logic [bfm_pkg::NEW_W-1:0]    out_bits_newly_set,
  output logic [bfm_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_length_error,
  input  logic                         cfg_we,
  input  logic [bfm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bfm_pkg::CDAT_W-1:0]   cfg_data
);
  import bfm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfm_dp #(
    .MAX_BITS      (MAX_BITS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_key_chunk       (in_key_chunk),
    .in_chunk_bytes     (in_chunk_bytes),
    .in_last_chunk      (in_last_chunk),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_present        (out_present),
    .out_bits_newly_set (out_bits_newly_set),
    .out_occupancy      (out_occupancy),
    .out_length_error   (out_length_error)
  );

`ifndef ASSERT_OFF
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_length_error) |-> (!out_present && out_bits_newly_set == '0))
    else $error("length error result changed bits");

  a_newly_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bits_newly_set <= NEW_W'(4)))
    else $error("too many newly set bits");
`endif

endmodule
